// ===== src/lli_pkg.sv =====
package lli_pkg;

   // Table geometry and data width
   localparam int DEPTH       = 32;
   localparam int DATA_W      = 16;
   localparam int IDX_W       = $clog2(DEPTH);
   localparam int N_W         = $clog2(DEPTH + 1);

   // Fixed field widths of the ports
   localparam int PTS_W       = 6;
   localparam int ENTRY_IDX_W = 5;
   localparam int PADDR_W     = 3;
   localparam int PDATA_W     = 32;

   // Arithmetic widths
   localparam int DIFF_W      = DATA_W + 1;
   localparam int PROD_W      = 2 * DATA_W;
   localparam int REM_W       = DATA_W + 1;
   localparam int SUM_W       = PROD_W + 2;
   localparam int DIV_STEPS   = PROD_W / 2;
   localparam int DCNT_W      = $clog2(DIV_STEPS);

   // Saturation limits of the result
   localparam logic signed [SUM_W-1:0] RES_MAX =
      {{(SUM_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
   localparam logic signed [SUM_W-1:0] RES_MIN =
      {{(SUM_W - DATA_W + 1){1'b1}}, {(DATA_W - 1){1'b0}}};

   // Item codes
   localparam logic CMD_QUERY = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   // Register index (word address bit)
   localparam logic REG_POINTS = 1'b0;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHK0,
      ST_CHKL,
      ST_STEP,
      ST_GET0,
      ST_GET1,
      ST_MUL,
      ST_DIV,
      ST_FIX,
      ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      RD_ZERO,
      RD_LAST,
      RD_MID,
      RD_LO,
      RD_LO1
   } rd_sel_type;

   typedef enum logic [2:0] {
      RES_ZERO,
      RES_RD_Y,
      RES_Y0,
      RES_YLAST,
      RES_DIV
   } res_sel_type;

   typedef struct packed {
      logic        start;
      logic        wr;
      logic        rd_en;
      rd_sel_type  rd_sel;
      logic        cap_last;
      logic        search_init;
      logic        search_step;
      logic        cap_lo;
      logic        cap_hi;
      logic        mul;
      logic        div_step;
      logic        res_load;
      res_sel_type res_sel;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic n_zero;
      logic n_one;
      logic q_le_x;
      logic q_ge_x;
      logic search_done;
      logic lo_last;
      logic dd_zero;
      logic div_done;
   } sts_type;

   // Magnitude of a difference; always fits DATA_W unsigned bits
   function automatic logic [DATA_W-1:0] mag_f(input logic signed [DIFF_W-1:0] v);
      logic signed [DIFF_W-1:0] a;
      a = v[DIFF_W-1] ? -v : v;
      return a[DATA_W-1:0];
   endfunction

endpackage

// ===== src/lut_linear_interp_1d.sv =====
// One-dimensional piecewise linear table lookup.
//
// Input channel (req_*): req_cmd selects a table write (loads entry
// req_entry_index with req_entry_x / req_entry_y) or a query at req_query_x.
// Output channel (rsp_*): one beat of rsp_result_y per query, none per write.
// A beat moves when valid is high and stall is low.
// Register points_in_use (byte address 0) sets how many entries take part.
//
// A write beat is taken in the idle state and does not close the input.
// A query holds req_stall high while it runs. It resolves in ST_CHK0 when the
// table is empty, holds one point or clamps at the first point, in ST_CHKL
// when it clamps at the last point, and otherwise runs the binary search
// (at most 5 steps for 32 entries) and, for a real interpolation, the divider.
// One table read per cycle through a single read port paces the search; the
// divider retires two quotient bits per cycle.
// The result sits in an output register, so the block goes back to taking
// beats while rsp_stall holds a finished result; a second result waits
// inside until the first is taken.
// Reset clears points_in_use and the control state; table contents are
// undefined until written.
module lut_linear_interp_1d (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_cmd,
   input  logic [lli_pkg::ENTRY_IDX_W-1:0]     req_entry_index,
   input  logic signed [lli_pkg::DATA_W-1:0]   req_entry_x,
   input  logic signed [lli_pkg::DATA_W-1:0]   req_entry_y,
   input  logic signed [lli_pkg::DATA_W-1:0]   req_query_x,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [lli_pkg::DATA_W-1:0]   rsp_result_y,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [lli_pkg::PADDR_W-1:0]         paddr,
   input  logic [lli_pkg::PDATA_W-1:0]         pwdata,
   output logic [lli_pkg::PDATA_W-1:0]         prdata,
   output logic                                pready
);
   import lli_pkg::*;

   logic [PTS_W-1:0] points_in_use_ff, points_in_use_in;
   logic             csr_wr;
   cmd_type          cmd;
   sts_type          sts;

   // Configuration register
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && (paddr[2] == REG_POINTS);

   always_comb begin
      points_in_use_in = points_in_use_ff;
      if (csr_wr) begin
         points_in_use_in = pwdata[PTS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         points_in_use_ff <= '0;
      end else begin
         points_in_use_ff <= points_in_use_in;
      end
   end

   assign prdata = (paddr[2] == REG_POINTS) ?
                   {{(PDATA_W - PTS_W){1'b0}}, points_in_use_ff} : '0;

   lli_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   lli_dpath u_dpath (
      .clock           (clock),
      .cmd             (cmd),
      .points_in_use   (points_in_use_ff),
      .req_entry_index (req_entry_index),
      .req_entry_x     (req_entry_x),
      .req_entry_y     (req_entry_y),
      .req_query_x     (req_query_x),
      .sts             (sts),
      .rsp_result_y    (rsp_result_y)
   );

endmodule

// ===== src/lli_ram.sv =====
module lli_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                       clock,
   input  logic                       we,
   input  logic [$clog2(DEPTH)-1:0]   waddr,
   input  logic [WIDTH-1:0]           wdata,
   input  logic                       re,
   input  logic [$clog2(DEPTH)-1:0]   raddr,
   output logic [WIDTH-1:0]           rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/lli_dpath.sv =====
module lli_dpath (
   input  logic                                clock,
   input  lli_pkg::cmd_type                    cmd,
   input  logic [lli_pkg::PTS_W-1:0]           points_in_use,
   input  logic [lli_pkg::ENTRY_IDX_W-1:0]     req_entry_index,
   input  logic signed [lli_pkg::DATA_W-1:0]   req_entry_x,
   input  logic signed [lli_pkg::DATA_W-1:0]   req_entry_y,
   input  logic signed [lli_pkg::DATA_W-1:0]   req_query_x,
   output lli_pkg::sts_type                    sts,
   output logic signed [lli_pkg::DATA_W-1:0]   rsp_result_y
);
   import lli_pkg::*;

   logic                      wr_ok;
   logic [IDX_W-1:0]          waddr;
   logic [IDX_W-1:0]          raddr;
   logic [DATA_W-1:0]         x_raw, y_raw;
   logic signed [DATA_W-1:0]  x_rd, y_rd;
   logic [N_W-1:0]            n_in;

   logic signed [DATA_W-1:0]  q_ff;
   logic [N_W-1:0]            n_ff;
   logic [IDX_W-1:0]          lo_ff, hi_ff, mid_ff;
   logic [IDX_W-1:0]          lo_in, hi_in, mid_in;
   logic [IDX_W-1:0]          lo_step, hi_step;
   logic [IDX_W:0]            mid_sum;
   logic signed [DATA_W-1:0]  ylast_ff, x0_ff, y0_ff;
   logic signed [DIFF_W-1:0]  dx_ff, dy_ff, dd_ff;
   logic                      neg_ff;
   logic [DATA_W-1:0]         dsr_ff;
   logic [PROD_W-1:0]         dvd_ff, dvd_in;
   logic [REM_W-1:0]          rem_ff, rem_in;
   logic [DCNT_W-1:0]         cnt_ff;
   logic signed [SUM_W-1:0]   y0_ext, quo_ext, sum, sat;
   logic signed [DATA_W-1:0]  res_in, res_ff, out_ff;

   // Table write: entries past the table depth are dropped
   assign wr_ok = ({{(32 - ENTRY_IDX_W){1'b0}}, req_entry_index} < 32'(DEPTH));
   assign waddr = IDX_W'(req_entry_index);

   // Count of points in use, capped at the table depth
   assign n_in = ({{(32 - PTS_W){1'b0}}, points_in_use} > 32'(DEPTH)) ?
                 N_W'(DEPTH) : N_W'(points_in_use);

   // One halving step of the search bounds
   always_comb begin
      if (x_rd <= q_ff) begin
         lo_step = mid_ff;
         hi_step = hi_ff;
      end else begin
         lo_step = lo_ff;
         hi_step = mid_ff - IDX_W'(1);
      end
   end

   // Search bounds: fresh range or one halving step
   always_comb begin
      if (cmd.search_init) begin
         lo_in = '0;
         hi_in = IDX_W'(n_ff - N_W'(1));
      end else begin
         lo_in = lo_step;
         hi_in = hi_step;
      end
      mid_sum = {1'b0, lo_in} + {1'b0, hi_in} + (IDX_W + 1)'(1);
      mid_in  = mid_sum[IDX_W:1];
   end

   // Read address select
   always_comb begin
      case (cmd.rd_sel)
         RD_ZERO: raddr = '0;
         RD_LAST: raddr = IDX_W'(n_ff - N_W'(1));
         RD_MID:  raddr = mid_in;
         RD_LO:   raddr = lo_in;
         RD_LO1:  raddr = lo_ff + IDX_W'(1);
         default: raddr = '0;
      endcase
   end

   lli_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_bp_ram (
      .clock (clock),
      .we    (cmd.wr && wr_ok),
      .waddr (waddr),
      .wdata (req_entry_x),
      .re    (cmd.rd_en),
      .raddr (raddr),
      .rdata (x_raw)
   );

   lli_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_val_ram (
      .clock (clock),
      .we    (cmd.wr && wr_ok),
      .waddr (waddr),
      .wdata (req_entry_y),
      .re    (cmd.rd_en),
      .raddr (raddr),
      .rdata (y_raw)
   );

   assign x_rd = $signed(x_raw);
   assign y_rd = $signed(y_raw);

   // Restoring divide, two quotient bits per cycle
   always_comb begin
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      for (int k = 0; k < 2; k++) begin
         rem_in = {rem_in[REM_W-2:0], dvd_in[PROD_W-1]};
         dvd_in = {dvd_in[PROD_W-2:0], 1'b0};
         if (rem_in >= {1'b0, dsr_ff}) begin
            rem_in    = rem_in - {1'b0, dsr_ff};
            dvd_in[0] = 1'b1;
         end
      end
   end

   // Apply signed quotient to y0 and saturate
   always_comb begin
      y0_ext  = {{(SUM_W - DATA_W){y0_ff[DATA_W-1]}}, y0_ff};
      quo_ext = $signed({2'b00, dvd_ff});
      sum     = neg_ff ? (y0_ext - quo_ext) : (y0_ext + quo_ext);
      if (sum > RES_MAX) begin
         sat = RES_MAX;
      end else if (sum < RES_MIN) begin
         sat = RES_MIN;
      end else begin
         sat = sum;
      end
   end

   // Result select
   always_comb begin
      case (cmd.res_sel)
         RES_ZERO:  res_in = '0;
         RES_RD_Y:  res_in = y_rd;
         RES_Y0:    res_in = y0_ff;
         RES_YLAST: res_in = ylast_ff;
         RES_DIV:   res_in = sat[DATA_W-1:0];
         default:   res_in = '0;
      endcase
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         q_ff <= req_query_x;
         n_ff <= n_in;
      end
      if (cmd.cap_last) begin
         ylast_ff <= y_rd;
      end
      if (cmd.search_init || cmd.search_step) begin
         lo_ff  <= lo_in;
         hi_ff  <= hi_in;
         mid_ff <= mid_in;
      end
      if (cmd.cap_lo) begin
         x0_ff <= x_rd;
         y0_ff <= y_rd;
      end
      if (cmd.cap_hi) begin
         dx_ff <= {q_ff[DATA_W-1], q_ff} - {x0_ff[DATA_W-1], x0_ff};
         dy_ff <= {y_rd[DATA_W-1], y_rd} - {y0_ff[DATA_W-1], y0_ff};
         dd_ff <= {x_rd[DATA_W-1], x_rd} - {x0_ff[DATA_W-1], x0_ff};
      end
      if (cmd.mul) begin
         dvd_ff <= PROD_W'(mag_f(dx_ff)) * PROD_W'(mag_f(dy_ff));
         dsr_ff <= mag_f(dd_ff);
         neg_ff <= dx_ff[DIFF_W-1] ^ dy_ff[DIFF_W-1] ^ dd_ff[DIFF_W-1];
         rem_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         dvd_ff <= dvd_in;
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff + DCNT_W'(1);
      end
      if (cmd.res_load) begin
         res_ff <= res_in;
      end
      if (cmd.out_load) begin
         out_ff <= res_ff;
      end
   end

   // Status to the controller
   assign sts.n_zero      = (n_ff == '0);
   assign sts.n_one       = (n_ff == N_W'(1));
   assign sts.q_le_x      = (q_ff <= x_rd);
   assign sts.q_ge_x      = (q_ff >= x_rd);
   assign sts.search_done = (lo_step >= hi_step);
   assign sts.lo_last     = ((N_W'(lo_ff) + N_W'(1)) >= n_ff);
   assign sts.dd_zero     = (dd_ff == '0);
   assign sts.div_done    = (cnt_ff == DCNT_W'(DIV_STEPS - 1));

   assign rsp_result_y = out_ff;

endmodule

// ===== src/lli_ctrl.sv =====
module lli_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_cmd,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  lli_pkg::sts_type  sts,
   output lli_pkg::cmd_type  cmd
);
   import lli_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // State and output-valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // Next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_cmd == CMD_WRITE) begin
                  cmd.wr = 1'b1;
               end else begin
                  cmd.start  = 1'b1;
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RD_ZERO;
                  state_in   = ST_CHK0;
               end
            end
         end
         // first entry: empty table, single point or clamp low
         ST_CHK0: begin
            if (sts.n_zero) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = RES_ZERO;
               state_in     = ST_OUT;
            end else if (sts.n_one || sts.q_le_x) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = RES_RD_Y;
               state_in     = ST_OUT;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_LAST;
               state_in   = ST_CHKL;
            end
         end
         // last entry: clamp high, else open the search (two or more points,
         // so at least one halving step follows)
         ST_CHKL: begin
            cmd.cap_last = 1'b1;
            if (sts.q_ge_x) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = RES_RD_Y;
               state_in     = ST_OUT;
            end else begin
               cmd.search_init = 1'b1;
               cmd.rd_en       = 1'b1;
               cmd.rd_sel      = RD_MID;
               state_in        = ST_STEP;
            end
         end
         // one halving per cycle
         ST_STEP: begin
            cmd.search_step = 1'b1;
            cmd.rd_en       = 1'b1;
            if (sts.search_done) begin
               cmd.rd_sel = RD_LO;
               state_in   = ST_GET0;
            end else begin
               cmd.rd_sel = RD_MID;
            end
         end
         ST_GET0: begin
            cmd.cap_lo = 1'b1;
            if (sts.lo_last) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = RES_YLAST;
               state_in     = ST_OUT;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_LO1;
               state_in   = ST_GET1;
            end
         end
         ST_GET1: begin
            cmd.cap_hi = 1'b1;
            state_in   = ST_MUL;
         end
         // equal breakpoints give y0
         ST_MUL: begin
            if (sts.dd_zero) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = RES_Y0;
               state_in     = ST_OUT;
            end else begin
               cmd.mul  = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_DIV;
            state_in     = ST_OUT;
         end
         // hand the result to the output register once it is free
         ST_OUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && rsp_stall);
   assign rsp_valid    = rsp_valid_ff;

endmodule

// ===== src/lli_checker.sv =====
module lli_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic                               req_cmd,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic signed [lli_pkg::DATA_W-1:0]  rsp_result_y
);
   import lli_pkg::*;

   // no result is left standing after reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // a query beat closes the input
   a_query_stalls: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_cmd == CMD_QUERY) |=> req_stall)
      else $error("input open right after a query beat");

   // a write beat never brings a result
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_cmd == CMD_WRITE) |=> !$rose(rsp_valid))
      else $error("result raised by a write beat");

   // a held result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_result_y)))
      else $error("stalled result changed");

endmodule

bind lut_linear_interp_1d lli_checker u_checker (.*);
